[rtl/serial_line_rgb_hex_command_top_assert.svh]
// Assertion macros used by the checker file of the serial RGB command block.
// Needs nothing else; included by the checker module.
`ifndef SERIAL_LINE_RGB_HEX_COMMAND_TOP_ASSERT_SVH
`define SERIAL_LINE_RGB_HEX_COMMAND_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SLRHC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("slrhc assertion failed");

// next-cycle implication, disabled in reset
`define SLRHC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("slrhc assertion failed");

`endif

[rtl/slrhc_pkg.sv]
// Package for the serial RGB command block: sizes, character codes, command
// record passed from front to back, hex decode and erase sequence. No deps.
package slrhc_pkg;

    localparam int LINE_MAX  = 50;
    localparam int HEAD_LEN  = 7;
    localparam int CNT_W     = $clog2(LINE_MAX + 1);
    localparam int MAXLEN_W  = 6;
    localparam int CMP_W     = (CNT_W > MAXLEN_W) ? CNT_W : MAXLEN_W;
    localparam int CFG_AW    = 1;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW   = $clog2(CMDQ_DEPTH);
    localparam int STEP_W    = 3;

    localparam logic [CFG_AW-1:0] CFG_ECHO_PLAIN = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MAX_LEN    = 1'b1;

    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_K     = 8'h4B;

    localparam logic [STEP_W-1:0] ERASE_LAST = 3'd6;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_CRLF  = 2'd2,
        KIND_LF    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] echo;
        logic       done;
        logic       ok;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cmd_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                hex_nibble = {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                hex_nibble = {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                hex_nibble = {1'b1, d[3:0]};
            end else begin
                hex_nibble = {1'b0, d[3:0]};
            end
        end
    endfunction

    // ESC [ 1 D ESC [ K
    function automatic logic [7:0] erase_byte(input logic [STEP_W-1:0] i);
        begin
            unique case (i)
                3'd0:    erase_byte = CH_ESC;
                3'd1:    erase_byte = CH_LBRK;
                3'd2:    erase_byte = CH_ONE;
                3'd3:    erase_byte = CH_D;
                3'd4:    erase_byte = CH_ESC;
                3'd5:    erase_byte = CH_LBRK;
                3'd6:    erase_byte = CH_K;
                default: erase_byte = CH_NUL;
            endcase
        end
    endfunction

endpackage

[rtl/slrhc_front.sv]
// Front end: takes received bytes, edits the line buffer, parses #rrggbb at
// line end, keeps config and duty registers, pushes commands. Uses slrhc_pkg.
module slrhc_front
    import slrhc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        rx_byte,
    output logic              full,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [MAXLEN_W-1:0] cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    logic                echo_plain_reg;
    logic [MAXLEN_W-1:0] max_len_reg;
    logic [CNT_W-1:0]    char_count_reg, char_count_next;
    logic [7:0]          head_reg [HEAD_LEN];
    logic [7:0]          head_next [HEAD_LEN];
    logic [7:0]          red_reg, green_reg, blue_reg;
    logic [7:0]          red_next, green_next, blue_next;

    logic             accept;
    logic             is_del, is_cr, is_lf, is_print;
    logic [CNT_W-1:0] cnt_inc, cnt_after;
    logic             ends;
    logic             ok;
    logic [4:0]       nib [6];
    logic             hex_ok;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign is_del   = (rx_byte == CH_DEL);
    assign is_cr    = (rx_byte == CH_CR);
    assign is_lf    = (rx_byte == CH_LF);
    assign is_print = (rx_byte >= CH_SPACE) && (rx_byte < CH_TILDE);

    assign cnt_inc   = char_count_reg + CNT_W'(1);
    assign cnt_after = is_print ? cnt_inc : char_count_reg;

    always_comb
    begin
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            head_next[i] = (is_print && char_count_reg == CNT_W'(i)) ? rx_byte : head_reg[i];
        end
    end

    // parse sees the character stored by this byte as well
    always_comb
    begin
        hex_ok = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            nib[i] = hex_nibble(head_next[i + 1]);
            hex_ok = hex_ok && nib[i][4];
        end
    end

    assign ok = (cnt_after >= CNT_W'(HEAD_LEN)) && (head_next[0] == CH_HASH) && hex_ok;

    assign ends = is_cr || is_lf ||
                  (is_print && ((CMP_W'(cnt_inc) >= CMP_W'(max_len_reg)) ||
                                (cnt_inc >= CNT_W'(LINE_MAX))));

    always_comb
    begin
        char_count_next = char_count_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        q_push          = 1'b0;
        q_cmd.kind      = KIND_ECHO;
        q_cmd.echo      = echo_plain_reg ? rx_byte : CH_STAR;
        q_cmd.done      = ends;
        q_cmd.ok        = ends && ok;
        if (accept)
        begin
            if (is_del)
            begin
                q_cmd.kind = KIND_ERASE;
                if (char_count_reg != '0)
                begin
                    char_count_next = char_count_reg - CNT_W'(1);
                    q_push          = 1'b1;
                end
            end
            else if (is_cr || is_lf || is_print)
            begin
                q_push = 1'b1;
                if (is_cr)
                begin
                    q_cmd.kind = KIND_CRLF;
                end
                else if (is_lf)
                begin
                    q_cmd.kind = KIND_LF;
                end
                char_count_next = ends ? '0 : cnt_inc;
                if (ends && ok)
                begin
                    red_next   = ~{nib[0][3:0], nib[1][3:0]};
                    green_next = ~{nib[2][3:0], nib[3][3:0]};
                    blue_next  = ~{nib[4][3:0], nib[5][3:0]};
                end
            end
        end
        q_cmd.red   = red_next;
        q_cmd.green = green_next;
        q_cmd.blue  = blue_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_plain_reg <= 1'b1;
            max_len_reg    <= MAXLEN_W'(49);
            char_count_reg <= '0;
            red_reg        <= 8'hFF;
            green_reg      <= 8'hFF;
            blue_reg       <= 8'hFF;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_ECHO_PLAIN: echo_plain_reg <= cfg_data[0];
                    CFG_MAX_LEN:    max_len_reg    <= cfg_data;
                    default:        ;
                endcase
            end
            char_count_reg <= char_count_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            blue_reg       <= blue_next;
        end
    end

    // line head has no reset; entries are only read after being written
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HEAD_LEN; i++)
            begin
                head_reg[i] <= head_next[i];
            end
        end
    end

endmodule

[rtl/slrhc_cmdq.sv]
// Small command FIFO between front and back of the serial RGB command block.
// Uses cmd_t from slrhc_pkg.
module slrhc_cmdq
    import slrhc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic q_empty
);

    cmd_t               mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_AW:0]   count_reg;

    assign q_full  = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_AW'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + (CMDQ_AW+1)'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - (CMDQ_AW+1)'(1);
            end
        end
    end

endmodule

[rtl/slrhc_back.sv]
// Back end: expands each queued command into result bytes, one per cycle when
// the one-entry output register is empty or popped. Uses slrhc_pkg.
module slrhc_back
    import slrhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_data,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] tx_byte,
    output logic       tx_present,
    output logic       line_done,
    output logic       color_ok,
    output logic [7:0] red_duty,
    output logic [7:0] green_duty,
    output logic [7:0] blue_duty,
    output logic       last
);

    logic              out_valid_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              load;
    logic [7:0]        tx_c;
    logic              present_c, done_c, last_c;

    logic [7:0] tx_reg, red_reg, green_reg, blue_reg;
    logic       present_reg, done_reg, ok_reg, last_reg;

    assign load  = !q_empty && (!out_valid_reg || pop);
    assign empty = !out_valid_reg;

    always_comb
    begin
        tx_c      = q_data.echo;
        present_c = 1'b1;
        done_c    = 1'b0;
        last_c    = 1'b1;
        unique case (q_data.kind)
            KIND_ECHO:
            begin
                done_c = q_data.done;
            end
            KIND_ERASE:
            begin
                tx_c   = erase_byte(step_reg);
                last_c = (step_reg == ERASE_LAST);
            end
            KIND_CRLF:
            begin
                // CR first, then LF which closes the line
                tx_c   = (step_reg == '0) ? CH_CR : CH_LF;
                done_c = (step_reg != '0);
                last_c = (step_reg != '0);
            end
            KIND_LF:
            begin
                tx_c      = CH_NUL;
                present_c = 1'b0;
                done_c    = 1'b1;
            end
            default: ;
        endcase
    end

    assign q_pop     = load && last_c;
    assign step_next = load ? (last_c ? '0 : step_reg + STEP_W'(1)) : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_reg      <= tx_c;
            present_reg <= present_c;
            done_reg    <= done_c;
            ok_reg      <= done_c && q_data.ok;
            last_reg    <= last_c;
            red_reg     <= q_data.red;
            green_reg   <= q_data.green;
            blue_reg    <= q_data.blue;
        end
    end

    assign tx_byte    = tx_reg;
    assign tx_present = present_reg;
    assign line_done  = done_reg;
    assign color_ok   = ok_reg;
    assign last       = last_reg;
    assign red_duty   = red_reg;
    assign green_duty = green_reg;
    assign blue_duty  = blue_reg;

endmodule

[rtl/serial_line_rgb_hex_command_top.sv]
// Serial line editor that sets three PWM duties from a "#rrggbb" command line.
// The front end takes one received byte per clock whenever its four-entry
// command queue has room (full low), updates the line and, at line end,
// parses the color and queues it in that same cycle. The back end drains
// the queue at one result per clock while its output register is empty or
// popped: a printable byte or LF gives 1 result, CR gives 2, DEL gives 7,
// so sustained throughput is set by the back end's step counter. Bytes that
// cause no result put nothing into the queue. No clearing pass after reset.
// Depends on slrhc_pkg, slrhc_front, slrhc_cmdq and slrhc_back.
module serial_line_rgb_hex_command_top
    import slrhc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [7:0]          rx_byte,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          tx_byte,
    output logic                tx_present,
    output logic                line_done,
    output logic                color_ok,
    output logic [7:0]          red_duty,
    output logic [7:0]          green_duty,
    output logic [7:0]          blue_duty,
    output logic                last,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [MAXLEN_W-1:0] cfg_data
);

    logic q_full, q_empty, q_push, q_pop;
    cmd_t q_wr, q_rd;

    slrhc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .full     (full),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_wr)
    );

    slrhc_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd),
        .q_empty (q_empty)
    );

    slrhc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rd),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .tx_byte    (tx_byte),
        .tx_present (tx_present),
        .line_done  (line_done),
        .color_ok   (color_ok),
        .red_duty   (red_duty),
        .green_duty (green_duty),
        .blue_duty  (blue_duty),
        .last       (last)
    );

endmodule

[rtl/slrhc_checker.sv]
// Port-level checker for the serial RGB command block, bound to the top.
// Uses slrhc_pkg and the macros in serial_line_rgb_hex_command_top_assert.svh.
`include "serial_line_rgb_hex_command_top_assert.svh"

module slrhc_checker
    import slrhc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  logic                pop,
    input  logic [7:0]          tx_byte,
    input  logic                tx_present,
    input  logic                line_done,
    input  logic                color_ok,
    input  logic                last
);

    // ok only ever rides on the request that closes the line
    `SLRHC_ASSERT_IMP(a_ok_needs_done, clk, rst_n, !empty && color_ok, line_done)

    // the closing request is always the final one for its byte
    `SLRHC_ASSERT_IMP(a_done_is_last, clk, rst_n, !empty && line_done, last)

    // silent requests only come from LF
    `SLRHC_ASSERT_IMP(a_silent_is_lf, clk, rst_n, !empty && !tx_present,
                      line_done && tx_byte == CH_NUL)

    // a waiting request stays until taken
    `SLRHC_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(tx_byte))

endmodule

bind serial_line_rgb_hex_command_top slrhc_checker u_slrhc_checker (.*);
